// ===== hw/rtl/lcddrv_pkg.sv =====
package lcddrv_pkg;

    localparam int unsigned WordW  = 16;
    localparam int unsigned FrameW = 2 * WordW;
    localparam int unsigned CntW   = $clog2(FrameW);
    localparam logic [CntW-1:0] LAST_BIT = CntW'(FrameW - 1);
    localparam logic [WordW-1:0] COLON_BIT = WordW'(1 << 7);

    typedef enum logic [1:0] {
        MODE_HM     = 2'd0,
        MODE_MS     = 2'd1,
        MODE_ALM_HM = 2'd2
    } mode_t;

    typedef struct packed {
        logic              common;
        logic [FrameW-1:0] bits;
    } frame_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    localparam logic [WordW-1:0] SEG_A [4][10] = '{
        '{16'd3, 16'd0, 16'd5, 16'd5, 16'd6, 16'd7, 16'd7, 16'd1, 16'd7, 16'd7},
        '{16'd56, 16'd8, 16'd88, 16'd88, 16'd104, 16'd112, 16'd112, 16'd24,
          16'd120, 16'd120},
        '{16'd1792, 16'd256, 16'd2816, 16'd2816, 16'd3328, 16'd3584, 16'd3584,
          16'd768, 16'd3840, 16'd3840},
        '{16'd28672, 16'd4096, 16'd45056, 16'd45056, 16'd53248, 16'd57344,
          16'd57344, 16'd12288, 16'd61440, 16'd61440}
    };

    localparam logic [WordW-1:0] SEG_B [4][10] = '{
        '{16'd15, 16'd3, 16'd13, 16'd7, 16'd3, 16'd6, 16'd14, 16'd3, 16'd15, 16'd7},
        '{16'd224, 16'd32, 16'd192, 16'd96, 16'd32, 16'd96, 16'd224, 16'd32,
          16'd224, 16'd96},
        '{16'd3584, 16'd512, 16'd3072, 16'd1536, 16'd512, 16'd1536, 16'd3584,
          16'd512, 16'd3584, 16'd1536},
        '{16'd28672, 16'd4096, 16'd24576, 16'd12288, 16'd4096, 16'd12288,
          16'd28672, 16'd4096, 16'd28672, 16'd12288}
    };

    // returns {word b, word a} for one digit position
    function automatic logic [FrameW-1:0] digit_segs(input logic [1:0] pos,
                                                     input logic [3:0] digit,
                                                     input logic blank_zero);
        logic [FrameW-1:0] r;
        r = '0;
        if (digit <= 4'd9 && !(blank_zero && digit == 4'd0)) begin
            r = {SEG_B[pos][digit], SEG_A[pos][digit]};
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/lcddrv_front.sv =====
module lcddrv_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [47:0]            s_tdata,
    input  lcddrv_pkg::q_stat_t    q_stat,
    output logic                   q_push,
    output lcddrv_pkg::frame_t     q_entry
);
    import lcddrv_pkg::*;

    logic              polarity_reg;
    logic              polarity_next;
    logic [3:0]        d0, d1, d2, d3;
    logic              blank3;
    logic              colon;
    logic [FrameW-1:0] segs;
    logic [1:0]        mode;
    logic [2:0]        eighth;

    assign mode   = s_tdata[1:0];
    assign eighth = s_tdata[28:26];

    always_comb begin
        d0     = '0;
        d1     = '0;
        d2     = '0;
        d3     = '0;
        blank3 = 1'b0;
        colon  = 1'b0;
        unique case (mode)
            MODE_HM: begin
                d0     = s_tdata[5:2];
                d1     = s_tdata[9:6];
                d2     = s_tdata[13:10];
                d3     = s_tdata[17:14];
                blank3 = 1'b1;
                colon  = eighth[2];
            end
            MODE_MS: begin
                d0    = s_tdata[21:18];
                d1    = s_tdata[25:22];
                d2    = s_tdata[5:2];
                d3    = s_tdata[9:6];
                colon = eighth[0];
            end
            MODE_ALM_HM: begin
                d0     = s_tdata[32:29];
                d1     = s_tdata[36:33];
                d2     = s_tdata[40:37];
                d3     = s_tdata[44:41];
                blank3 = 1'b1;
                colon  = 1'b1;
            end
            default: begin
                // unused mode: all segments off, digits forced out of range
                d0 = 4'hf;
                d1 = 4'hf;
                d2 = 4'hf;
                d3 = 4'hf;
            end
        endcase
    end

    always_comb begin
        segs = digit_segs(2'd0, d0, 1'b0) | digit_segs(2'd1, d1, 1'b0)
             | digit_segs(2'd2, d2, 1'b0) | digit_segs(2'd3, d3, blank3);
        if (colon) begin
            segs[WordW-1:0] = segs[WordW-1:0] | COLON_BIT;
        end
    end

    assign s_tready       = !q_stat.full;
    assign q_push         = s_tvalid && s_tready;
    assign polarity_next  = !polarity_reg;
    assign q_entry.common = polarity_next;
    assign q_entry.bits   = polarity_reg ? segs : ~segs;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            polarity_reg <= 1'b0;
        end else if (q_push) begin
            polarity_reg <= polarity_next;
        end
    end

endmodule

// ===== hw/rtl/lcddrv_queue.sv =====
module lcddrv_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  lcddrv_pkg::frame_t  wr_entry,
    input  logic                pop,
    output lcddrv_pkg::frame_t  rd_entry,
    output lcddrv_pkg::q_stat_t stat
);
    import lcddrv_pkg::*;

    frame_t     mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign stat.full  = cnt_reg == 2'd2;
    assign stat.empty = cnt_reg == 2'd0;
    assign rd_entry   = mem_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== hw/rtl/lcddrv_back.sv =====
module lcddrv_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  lcddrv_pkg::frame_t  q_entry,
    input  lcddrv_pkg::q_stat_t q_stat,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,  // [0] data_bit
    output logic                m_tlast,
    output logic [0:0]          m_tuser   // [0] common_level
);
    import lcddrv_pkg::*;

    logic [FrameW-1:0] shift_reg;
    logic [CntW-1:0]   cnt_reg;
    logic              busy_reg;
    logic              common_reg;
    logic              last;
    logic              xfer;

    assign last     = cnt_reg == LAST_BIT;
    assign xfer     = busy_reg && m_tready;
    assign q_pop    = !q_stat.empty && (!busy_reg || (xfer && last));
    assign m_tvalid = busy_reg;
    assign m_tdata  = {7'd0, shift_reg[0]};
    assign m_tlast  = last;
    assign m_tuser  = last & common_reg;

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            shift_reg  <= q_entry.bits;
            common_reg <= q_entry.common;
        end else if (xfer) begin
            shift_reg <= {1'b0, shift_reg[FrameW-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (q_pop) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (xfer) begin
            busy_reg <= !last;
            cnt_reg  <= cnt_reg + CntW'(1);
        end
    end

endmodule

// ===== hw/rtl/segment_lcd_ac_display_driver_unit.sv =====
// channel | dir | tdata                                     | tlast | tuser
// s_      | in  | 48b refresh: mode, time, eighths, alarm   | -     | -
// m_      | out | 8b, [0] serial segment bit                | latch | [0] common_level
//
// one refresh gives 32 output transactions, one a cycle while m_tready is high:
// the bit shifter in the back end sets the rate; refreshes run back to back when queued
// input to first bit: written into the two-entry frame queue, then loaded into the shifter
// reset: synchronous aresetn low clears polarity, queue pointers and count, and the shifter's busy flag and bit count
// output stall holds the shifter; the queue keeps taking refreshes until full
module segment_lcd_ac_display_driver_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // mode[1:0] min1[5:2] min10[9:6] hr1[13:10] hr10[17:14]
                                  // sec1[21:18] sec10[25:22] eighth[28:26] amin1[32:29]
                                  // amin10[36:33] ahr1[40:37] ahr10[44:41]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // data_bit[0]
    output logic        m_tlast,
    output logic [0:0]  m_tuser   // common_level[0]
);
    import lcddrv_pkg::*;

    frame_t  wr_entry;
    frame_t  rd_entry;
    q_stat_t q_stat;
    logic    q_push;
    logic    q_pop;

    lcddrv_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_entry  (wr_entry)
    );

    lcddrv_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_entry (wr_entry),
        .pop      (q_pop),
        .rd_entry (rd_entry),
        .stat     (q_stat)
    );

    lcddrv_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_entry  (rd_entry),
        .q_stat   (q_stat),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    a_common_only_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("common level outside last bit");

    a_queue_status: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty");

    a_accept_fills_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !q_stat.empty)
        else $error("accepted refresh missing from queue");

    a_pop_needs_data: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");

endmodule
